// ----- src/connection_timeout_queue_assert.svh -----
// Assertion macros for the connection timeout queue
`ifndef CONNECTION_TIMEOUT_QUEUE_ASSERT_SVH
`define CONNECTION_TIMEOUT_QUEUE_ASSERT_SVH
// implication check under synchronous reset
`define CTQ_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// next-cycle check
`define CTQ_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// ----- src/ctq_pkg.sv -----
// Package: types and constants of the connection timeout queue
`timescale 1ns / 1ps
package ctq_pkg;
   localparam int CAPACITY_DEF = 32;
   localparam int MAX_RESULTS = 32;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;
   localparam logic [1:0] ST_EXPIRED = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_KICK = 1'b1;

   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] conn_id;
      logic [31:0] sequence_v;
   } entry_type;

   // chain operation broadcast to every cell
   typedef struct packed {
      logic       ins;     // sorted insert of new_entry
      logic       del;     // compact out matching conn_id
      logic       pop;     // shift toward head by one
      logic       clr;
      entry_type  new_entry;
      logic [15:0] del_id;
   } chain_op_type;
endpackage

// ----- src/connection_timeout_queue.sv -----
// Top level: sorted connection timeout queue built on a cell chain
// Usage:
//  req_ channel takes one command word (insert, delete, tick, clear).
//  rsp_ channel returns result words; rsp_tlast marks the final one.
//  csr_ channel writes timeout_seconds (index 0) and kick_enable (1);
//  write it only while no command is in work.
//  Insert and clear: accepted in S_IDLE, the chain op and the result
//  word are registered together in S_OUT, which waits while the result
//  register is held; then S_IDLE takes the next command.
//  Delete: the chain closes one gap per cycle until no match remains.
//  Tick: a check step (S_TICK) that also counts the due entries, then per
//  due entry a pop step and, when requeueing, an insert step; at most
//  32 entries per tick, the first expired word registered in S_POP.
//  Each step applies at most one chain op (insert, delete, pop or clear).
//  Reset empties the chain at once (valid bits clear in every cell).
//  A stalled receiver holds the result register; steps that write a new result word wait for it.
//  One command is in work at a time; req_tready is low while busy.
`timescale 1ns / 1ps
`include "connection_timeout_queue_assert.svh"
module connection_timeout_queue #(
   parameter int CAPACITY = ctq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // conn_id, sequence_req, now
   input  logic [1:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_conn_id, out_sequence, removed_count
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int RES_W = $clog2(ctq_pkg::MAX_RESULTS + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_DEL = 5'b00010, S_TICK = 5'b00100,
      S_POP = 5'b01000, S_OUT = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [15:0]      timeout_ff;
   logic             kick_ff;
   logic [1:0]       cmd_ff, cmd_in;
   logic [15:0]      cid_ff, cid_in;
   logic [31:0]      seq_ff, seq_in;
   logic [31:0]      now_ff, now_in;
   logic [6:0]       rem_ff, rem_in;
   logic [RES_W-1:0] due_ff, due_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;   // due entries still to emit this tick
   logic             ov_ff, ov_in;
   logic [1:0]       ost_ff, ost_in;
   logic [15:0]      ocid_ff, ocid_in;
   logic [31:0]      oseq_ff, oseq_in;
   logic [6:0]       orem_ff, orem_in;
   logic             olast_ff, olast_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             back_ff, back_in;  // in tick: next S_POP step requeues the entry just emitted

   ctq_pkg::chain_op_type op;
   ctq_pkg::entry_type    head;
   logic                  head_valid, any_match, full;
   logic [CNT_W-1:0]      due_cnt;
   logic [32:0]           sum;
   logic [31:0]           exp_v;
   logic                  out_free;
   logic                  tick_last;

   assign sum = {1'b0, now_ff} + {17'd0, timeout_ff};
   assign exp_v = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign out_free = !ov_ff || rsp_tready;
   assign tick_last = (cnt_ff == CNT_W'(1))
                      || (due_ff == RES_W'(ctq_pkg::MAX_RESULTS - 1));

   ctq_chain #(.CAPACITY(CAPACITY), .CNT_W(CNT_W)) u_chain (
      .clock(clock), .reset(reset), .op(op),
      .head(head), .head_valid(head_valid), .any_match(any_match), .full(full),
      .due_cnt(due_cnt)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = ov_ff;
   assign rsp_tuser = ost_ff;
   assign rsp_tdata = {1'b0, orem_ff, oseq_ff, ocid_ff};
   assign rsp_tlast = olast_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; cid_in = cid_ff; seq_in = seq_ff; now_in = now_ff;
      rem_in = rem_ff; due_in = due_ff; cnt_in = cnt_ff; back_in = back_ff;
      ov_in = ov_ff && !rsp_tready;
      ost_in = ost_ff; ocid_in = ocid_ff; oseq_in = oseq_ff;
      orem_in = orem_ff; olast_in = olast_ff; fill_in = fill_ff;
      op = '0;
      op.del_id = cid_ff;
      op.new_entry.expiry = exp_v;
      op.new_entry.conn_id = cid_ff;
      op.new_entry.sequence_v = seq_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tuser;
               cid_in = req_tdata[15:0];
               seq_in = req_tdata[47:16];
               now_in = req_tdata[79:48];
               rem_in = '0;
               due_in = '0;
               case (req_tuser)
                  ctq_pkg::CMD_DELETE: state_in = S_DEL;
                  ctq_pkg::CMD_TICK:   state_in = S_TICK;
                  default:             state_in = S_OUT;
               endcase
            end
         end
         S_OUT: begin
            // insert or clear: at most one chain op, with the result word in the same step
            if (out_free) begin
               ocid_in = '0; oseq_in = '0; orem_in = '0; olast_in = 1'b1;
               ost_in = ctq_pkg::ST_DONE;
               if (cmd_ff == ctq_pkg::CMD_CLEAR) begin
                  op.clr = 1'b1;
                  fill_in = '0;
               end else if (full) begin
                  ost_in = ctq_pkg::ST_FULL;
               end else begin
                  op.ins = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DEL: begin
            if (any_match) begin
               op.del = 1'b1;
               rem_in = rem_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
            end else if (out_free) begin
               ost_in = ctq_pkg::ST_DONE; ocid_in = '0; oseq_in = '0;
               orem_in = rem_ff; olast_in = 1'b1; ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            // compare against now to count the due prefix
            op.new_entry.expiry = now_ff;
            if (!head_valid || !(head.expiry < now_ff)) begin
               if (out_free) begin
                  ost_in = ctq_pkg::ST_DONE; ocid_in = '0; oseq_in = '0;
                  orem_in = '0; olast_in = 1'b1; ov_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cnt_in = due_cnt;
               back_in = 1'b0;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (back_ff) begin
               // requeue the entry just emitted
               op.ins = 1'b1;
               fill_in = fill_ff + 1'b1;
               back_in = 1'b0;
               if (cnt_ff == '0 || due_ff == RES_W'(ctq_pkg::MAX_RESULTS)) begin
                  state_in = S_IDLE;
               end
            end else if (out_free) begin
               op.pop = 1'b1;
               fill_in = fill_ff - 1'b1;
               cnt_in = cnt_ff - 1'b1;
               due_in = due_ff + 1'b1;
               cid_in = head.conn_id;
               seq_in = head.sequence_v;
               ost_in = ctq_pkg::ST_EXPIRED; ocid_in = head.conn_id;
               oseq_in = head.sequence_v; orem_in = '0; olast_in = tick_last;
               ov_in = 1'b1;
               back_in = !kick_ff;
               if (tick_last && kick_ff) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         fill_ff <= '0;
         timeout_ff <= 16'd60;
         kick_ff <= 1'b0;
         back_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         fill_ff <= fill_in;
         back_ff <= back_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == ctq_pkg::CSR_TIMEOUT) timeout_ff <= csr_data;
            else if (csr_index == ctq_pkg::CSR_KICK) kick_ff <= csr_data[0];
         end
      end
      cmd_ff <= cmd_in; cid_ff <= cid_in; seq_ff <= seq_in; now_ff <= now_in;
      rem_ff <= rem_in; due_ff <= due_in; cnt_ff <= cnt_in;
      ost_ff <= ost_in; ocid_ff <= ocid_in; oseq_ff <= oseq_in;
      orem_ff <= orem_in; olast_ff <= olast_in;
   end

   `CTQ_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready && state_ff == S_IDLE,
      rsp_tvalid, "result dropped while stalled")
   `CTQ_ASSERT_IMP(a_busy, clock, reset, state_ff != S_IDLE, !req_tready,
      "command accepted while busy")
   `CTQ_ASSERT_IMP(a_fill, clock, reset, 1'b1, fill_ff <= CNT_W'(CAPACITY),
      "fill count beyond capacity")
endmodule

// ----- src/ctq_cell.sv -----
// One queue cell: holds an entry, shifts with its neighbors
`timescale 1ns / 1ps
module ctq_cell #(
   parameter int CNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctq_pkg::chain_op_type op,
   input  logic                 prev_valid,
   input  ctq_pkg::entry_type   prev_entry,
   input  logic                 prev_goes_after, // prev entry's expiry <= new expiry
   input  logic                 next_valid,
   input  ctq_pkg::entry_type   next_entry,
   input  logic [CNT_W-1:0]     prev_kill,       // matches at or before previous cell
   output logic                 valid,
   output ctq_pkg::entry_type   entry,
   output logic                 goes_after,
   output logic                 match
);
   logic               valid_ff, valid_in;
   ctq_pkg::entry_type entry_ff, entry_in;
   logic               here_after;

   assign here_after = valid_ff && (entry_ff.expiry <= op.new_entry.expiry);
   assign goes_after = here_after;
   assign match = valid_ff && (entry_ff.conn_id == op.del_id);
   assign valid = valid_ff;
   assign entry = entry_ff;

   // clear, insert, pop; a delete compacts one cell per cycle until no match remains
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (op.clr) begin
         valid_in = 1'b0;
      end else if (op.ins) begin
         if (!here_after) begin
            if (prev_goes_after) begin
               valid_in = 1'b1;
               entry_in = op.new_entry;
            end else if (prev_valid) begin
               valid_in = 1'b1;
               entry_in = prev_entry;
            end
         end
      end else if (op.pop || (op.del && (match || prev_kill != '0))) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      entry_ff <= entry_in;
   end
endmodule

// ----- src/ctq_chain.sv -----
// Row of queue cells with head, insert position and match reduction
`timescale 1ns / 1ps
module ctq_chain #(
   parameter int CAPACITY = ctq_pkg::CAPACITY_DEF,
   parameter int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctq_pkg::chain_op_type op,
   output ctq_pkg::entry_type   head,
   output logic                 head_valid,
   output logic                 any_match,
   output logic                 full,
   output logic [CNT_W-1:0]     due_cnt
);
   logic               v [CAPACITY+1];
   ctq_pkg::entry_type e [CAPACITY+1];
   logic               ga [CAPACITY+1];
   logic               m [CAPACITY];
   logic [CNT_W-1:0]   k [CAPACITY+1];

   assign v[CAPACITY] = 1'b0;
   assign e[CAPACITY] = '0;

   // k[i]: a match exists at or before cell i-1 (first-match flag)
   assign k[0] = '0;
   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic pv, pg;
         ctq_pkg::entry_type pe;
         if (g == 0) begin : g_h
            assign pv = 1'b0;
            assign pg = 1'b1;
            assign pe = '0;
         end else begin : g_b
            assign pv = v[g-1];
            assign pg = ga[g-1];
            assign pe = e[g-1];
         end
         assign k[g+1] = (k[g] != '0 || m[g]) ? CNT_W'(1) : '0;
         ctq_cell #(.CNT_W(CNT_W)) u_cell (
            .clock(clock), .reset(reset), .op(op),
            .prev_valid(pv), .prev_entry(pe), .prev_goes_after(pg),
            .next_valid(v[g+1]), .next_entry(e[g+1]),
            .prev_kill(k[g]),
            .valid(v[g]), .entry(e[g]), .goes_after(ga[g]), .match(m[g])
         );
      end
   endgenerate
   assign ga[CAPACITY] = 1'b0;

   // goes_after is a prefix of the sorted row: its end gives the count
   always_comb begin
      due_cnt = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ga[i] && !ga[i+1]) due_cnt = due_cnt | CNT_W'(i + 1);
      end
   end

   assign head = e[0];
   assign head_valid = v[0];
   assign any_match = k[CAPACITY] != '0;
   assign full = v[CAPACITY-1];
endmodule
